>>> src/urzc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, register map and reset values for the ultrasonic range zone classifier.
// No dependencies; imported by the top level and its checker.

package urzc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_HIGH = 2'd3
  } phase_t;

  // configuration register indexes
  localparam logic [2:0] CFG_NEAR_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_MID_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_FAR_LIMIT   = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT     = 3'd3;
  localparam logic [2:0] CFG_TRIGGER     = 3'd4;
  localparam logic [2:0] CFG_AVG_LOG2    = 3'd5;
  localparam logic [2:0] CFG_CLEAR_TMO   = 3'd6;

  // zone codes
  localparam logic [1:0] ZONE_NEAR = 2'd0;
  localparam logic [1:0] ZONE_MID  = 2'd1;
  localparam logic [1:0] ZONE_FAR  = 2'd2;
  localparam logic [1:0] ZONE_NONE = 2'd3;

  // register reset values
  localparam logic [9:0]  RST_NEAR_LIMIT = 10'd60;
  localparam logic [9:0]  RST_MID_LIMIT  = 10'd110;
  localparam logic [9:0]  RST_FAR_LIMIT  = 10'd200;
  localparam logic [15:0] RST_TIMEOUT    = 16'd25000;
  localparam logic [7:0]  RST_TRIGGER    = 8'd10;
  localparam logic [1:0]  RST_AVG_LOG2   = 2'd0;
  localparam logic        RST_CLEAR_TMO  = 1'b1;

  // 340 m/s * 1e-4 / 2 per microsecond = 17 / 1000 cm
  localparam logic [10:0] CM_NUM   = 11'd17;
  localparam logic [10:0] CM_DEN   = 11'd1000;
  localparam logic [10:0] DIST_MAX = 11'd1114;

  function automatic logic [1:0] classify(input logic [10:0] d, input logic [9:0] near_lim,
                                          input logic [9:0] mid_lim, input logic [9:0] far_lim);
    logic [1:0] z;
    if (d < {1'b0, near_lim}) begin
      z = ZONE_NEAR;
    end else if (d < {1'b0, mid_lim}) begin
      z = ZONE_MID;
    end else if (d < {1'b0, far_lim}) begin
      z = ZONE_FAR;
    end else begin
      z = ZONE_NONE;
    end
    return z;
  endfunction

endpackage

`default_nettype wire

>>> src/ultrasonic_range_zone_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Ultrasonic echo ranger: trigger, echo width timing, averaging and zone sorting.
// Depends on urzc_pkg.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | start_req, echo_level (one tick)
//   out_    | output    | out_valid/out_ready | trigger, status, distance, zone
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index (3b), cfg_data (16b)
//
// One transaction in, one out: the tick is processed between the state registers
// and the result register, so in_ready stays high unless a result is held.
// Distance is kept as running quotient and remainder of sum*17/1000, so closing an
// average is only a shift, a saturate and three compares.
// rst_n is synchronous; it clears state and loads register defaults.
// A stalled output holds its result and blocks the input until taken.

module ultrasonic_range_zone_classifier_unit
  import urzc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_start_req,
  input  wire logic        in_echo_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_trigger_out,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic             out_timed_out,
  output logic             out_zone_updated,
  output logic [10:0]      out_distance_cm,
  output logic [1:0]       out_zone,
  output logic             out_path_clear,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration
  logic [9:0]  near_r, mid_r, far_r;
  logic [15:0] timeout_r;
  logic [7:0]  trigger_r;
  logic [1:0]  avg_log2_r;
  logic        clear_tmo_r;

  // measurement state
  phase_t      phase_r, phase_nxt, ph_cur;
  logic [15:0] elapsed_r, elapsed_nxt, el_cur, el_inc;
  logic [15:0] ew_r, ew_nxt, ew_cur;
  logic [13:0] cq_r, cq_nxt, rq_r, rq_nxt;   // committed / running quotient
  logic [9:0]  cr_r, cr_nxt, rr_r, rr_nxt;   // committed / running remainder
  logic [3:0]  sc_r, sc_nxt;
  logic [10:0] dist_r, dist_nxt;
  logic [1:0]  zone_r, zone_nxt;

  // per-tick flags
  logic trig, busy, done, tout, upd;

  logic        in_fire;
  logic        start_new;
  logic [10:0] r_add;
  logic [13:0] q_add;
  logic [9:0]  r_add_w;
  logic [13:0] dq;
  logic [10:0] d_sat;
  logic [3:0]  n_avg;

  logic       out_valid_r;
  logic       trig_r, busy_r, done_r, tout_r, upd_r;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign start_new = (phase_r == PH_IDLE) && in_start_req;
  assign ph_cur    = start_new ? PH_TRIG : phase_r;
  assign el_cur    = start_new ? '0 : elapsed_r;
  assign ew_cur    = start_new ? '0 : ew_r;
  assign el_inc    = (el_cur != 16'hFFFF) ? el_cur + 16'd1 : el_cur;

  // running sum plus one more microsecond of echo
  assign r_add   = {1'b0, rr_r} + CM_NUM;
  assign q_add   = (r_add >= CM_DEN) ? rq_r + 14'd1 : rq_r;
  assign r_add_w = (r_add >= CM_DEN) ? 10'(r_add - CM_DEN) : r_add[9:0];

  assign dq    = rq_r >> avg_log2_r;
  assign d_sat = (dq > {3'd0, DIST_MAX}) ? DIST_MAX : dq[10:0];
  assign n_avg = 4'd1 << avg_log2_r;

  always_comb begin
    phase_nxt   = ph_cur;
    elapsed_nxt = el_cur;
    ew_nxt      = ew_cur;
    cq_nxt      = cq_r;
    cr_nxt      = cr_r;
    rq_nxt      = rq_r;
    rr_nxt      = rr_r;
    sc_nxt      = sc_r;
    dist_nxt    = dist_r;
    zone_nxt    = zone_r;
    trig        = 1'b0;
    busy        = 1'b0;
    done        = 1'b0;
    tout        = 1'b0;
    upd         = 1'b0;

    if (ph_cur != PH_IDLE) begin
      busy = 1'b1;
      case (ph_cur)
        PH_TRIG: begin
          trig = 1'b1;
          if ({1'b0, el_cur} + 17'd1 >= {9'd0, trigger_r}) begin
            phase_nxt = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (in_echo_level) begin
            phase_nxt = PH_HIGH;
            ew_nxt    = 16'd1;
            rq_nxt    = q_add;
            rr_nxt    = r_add_w;
          end
        end
        PH_HIGH: begin
          if (in_echo_level) begin
            if (ew_cur != 16'hFFFF) begin
              ew_nxt = ew_cur + 16'd1;
              rq_nxt = q_add;
              rr_nxt = r_add_w;
            end
          end else begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
            cq_nxt    = rq_r;
            cr_nxt    = rr_r;
            sc_nxt    = sc_r + 4'd1;
            if ({1'b0, sc_r} + 5'd1 >= {1'b0, n_avg}) begin
              dist_nxt = d_sat;
              zone_nxt = classify(d_sat, near_r, mid_r, far_r);
              upd      = 1'b1;
              cq_nxt   = '0;
              cr_nxt   = '0;
              rq_nxt   = '0;
              rr_nxt   = '0;
              sc_nxt   = '0;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      elapsed_nxt = el_inc;
      if (!done && el_inc >= timeout_r) begin
        done      = 1'b1;
        tout      = 1'b1;
        phase_nxt = PH_IDLE;
        // drop the partial width, keep the committed sum
        rq_nxt    = cq_r;
        rr_nxt    = cr_r;
        if (clear_tmo_r) begin
          zone_nxt = ZONE_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      ew_r      <= '0;
      cq_r      <= '0;
      cr_r      <= '0;
      rq_r      <= '0;
      rr_r      <= '0;
      sc_r      <= '0;
      dist_r    <= '0;
      zone_r    <= ZONE_NONE;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      ew_r      <= ew_nxt;
      cq_r      <= cq_nxt;
      cr_r      <= cr_nxt;
      rq_r      <= rq_nxt;
      rr_r      <= rr_nxt;
      sc_r      <= sc_nxt;
      dist_r    <= dist_nxt;
      zone_r    <= zone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r      <= RST_NEAR_LIMIT;
      mid_r       <= RST_MID_LIMIT;
      far_r       <= RST_FAR_LIMIT;
      timeout_r   <= RST_TIMEOUT;
      trigger_r   <= RST_TRIGGER;
      avg_log2_r  <= RST_AVG_LOG2;
      clear_tmo_r <= RST_CLEAR_TMO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NEAR_LIMIT: near_r      <= cfg_data[9:0];
        CFG_MID_LIMIT:  mid_r       <= cfg_data[9:0];
        CFG_FAR_LIMIT:  far_r       <= cfg_data[9:0];
        CFG_TIMEOUT:    timeout_r   <= cfg_data;
        CFG_TRIGGER:    trigger_r   <= cfg_data[7:0];
        CFG_AVG_LOG2:   avg_log2_r  <= cfg_data[1:0];
        CFG_CLEAR_TMO:  clear_tmo_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [10:0] res_dist_r;
  logic [1:0]  res_zone_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      trig_r     <= trig;
      busy_r     <= busy;
      done_r     <= done;
      tout_r     <= tout;
      upd_r      <= upd;
      res_dist_r <= dist_nxt;
      res_zone_r <= zone_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_trigger_out  = trig_r;
  assign out_busy_res     = busy_r;
  assign out_done_res     = done_r;
  assign out_timed_out    = tout_r;
  assign out_zone_updated = upd_r;
  assign out_distance_cm  = res_dist_r;
  assign out_zone         = res_zone_r;
  assign out_path_clear   = (res_zone_r == ZONE_FAR) || (res_zone_r == ZONE_NONE);

endmodule

`default_nettype wire

>>> src/urzc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the ultrasonic range zone classifier, bound to the top level.
// Depends on urzc_pkg and ultrasonic_range_zone_classifier_unit.

module urzc_checker
  import urzc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_trigger_out,
  input wire logic        out_busy_res,
  input wire logic        out_done_res,
  input wire logic        out_timed_out,
  input wire logic        out_zone_updated,
  input wire logic [10:0] out_distance_cm,
  input wire logic [1:0]  out_zone
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_cm) && $stable(out_zone)
      && $stable(out_done_res))
    else $error("result changed while stalled");

  // every accepted tick yields a result on the next cycle
  a_one_per_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");

  a_timeout_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> out_done_res && out_busy_res && !out_zone_updated)
    else $error("timeout without a busy ending transaction");

  a_update_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zone_updated |-> out_done_res && !out_timed_out
      && out_distance_cm <= DIST_MAX)
    else $error("zone update outside an echo ending");

  // a trigger tick can only end by a timeout
  a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger_out |-> out_busy_res && (!out_done_res || out_timed_out))
    else $error("trigger driven outside the trigger phase");

endmodule

bind ultrasonic_range_zone_classifier_unit urzc_checker u_urzc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_trigger_out  (out_trigger_out),
  .out_busy_res     (out_busy_res),
  .out_done_res     (out_done_res),
  .out_timed_out    (out_timed_out),
  .out_zone_updated (out_zone_updated),
  .out_distance_cm  (out_distance_cm),
  .out_zone         (out_zone)
);

`default_nettype wire

>>> test/tb_ultrasonic_range_zone_classifier_unit.sv
`timescale 1ns / 1ps
// Testbench for ultrasonic_range_zone_classifier_unit: a scripted run of echo ticks, then
// random measurements, every output tick checked against the in-bench model or script.
// Depends on urzc_pkg and the unit RTL.

module tb_ultrasonic_range_zone_classifier_unit;
  import urzc_pkg::*;

  localparam int unsigned RUN_LIMIT    = 25_000_000;
  localparam int unsigned RANDOM_TICKS = 400;
  localparam int unsigned US_CM_NUM    = 17;
  localparam int unsigned US_CM_DEN    = 1000;
  localparam int unsigned DIST_CAP     = 1114;
  localparam logic [2:0]  CFG_UNUSED   = 3'd7;

  typedef struct packed {
    logic        trig;
    logic        busy;
    logic        done;
    logic        tout;
    logic        upd;
    logic [10:0] dist_cm;
    logic [1:0]  zone;
    logic        clear;
  } ranger_out_t;

  typedef enum logic {ROW_TICKS, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    logic        start;
    logic        echo;
    logic [16:0] reps;
    logic        typed;
    ranger_out_t want;
  } script_row_t;

  localparam ranger_out_t UNTYPED        = '0;
  localparam ranger_out_t IDLE_AT_RESET  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0, ZONE_NONE, 1'b1};
  localparam ranger_out_t FIRST_NEAR     = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 11'd3, ZONE_NEAR, 1'b0};
  localparam ranger_out_t PAIR_CLOSED    = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 11'd5, ZONE_NEAR, 1'b0};
  localparam ranger_out_t ABORT_AT_START = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 11'd1, ZONE_NONE, 1'b1};

  // width 200 at default limits, then a two-width sum closed by one, then limit and
  // timeout corners
  localparam script_row_t SCRIPT [0:25] = '{
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b0, 1'b0, 17'd1,     1'b1, IDLE_AT_RESET},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b1, 1'b1, 17'd10,    1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b0, 1'b0, 17'd4,     1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b1, 1'b1, 17'd200,   1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b0, 1'b0, 17'd1,     1'b1, FIRST_NEAR},
    '{ROW_WRITE, CFG_TRIGGER,    16'd0,     1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_WRITE, CFG_TIMEOUT,    16'hFFFF,  1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_WRITE, CFG_AVG_LOG2,   16'd1,     1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b1, 1'b0, 17'd1,     1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b0, 1'b1, 17'd150,   1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b0, 1'b0, 17'd1,     1'b0, UNTYPED},
    '{ROW_WRITE, CFG_AVG_LOG2,   16'd0,     1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b1, 1'b1, 17'd151,   1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b0, 1'b0, 17'd1,     1'b1, PAIR_CLOSED},
    '{ROW_WRITE, CFG_NEAR_LIMIT, 16'd1023,  1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_WRITE, CFG_MID_LIMIT,  16'd1023,  1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_WRITE, CFG_FAR_LIMIT,  16'd1023,  1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b1, 1'b1, 17'd60,    1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b0, 1'b0, 17'd1,     1'b0, UNTYPED},
    '{ROW_WRITE, CFG_CLEAR_TMO,  16'd0,     1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_WRITE, CFG_TRIGGER,    16'd255,   1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_WRITE, CFG_TIMEOUT,    16'd5,     1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b1, 1'b0, 17'd5,     1'b0, UNTYPED},
    '{ROW_WRITE, CFG_CLEAR_TMO,  16'd1,     1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_WRITE, CFG_TIMEOUT,    16'd0,     1'b0, 1'b0, 17'd0,     1'b0, UNTYPED},
    '{ROW_TICKS, CFG_NEAR_LIMIT, 16'd0,     1'b1, 1'b0, 17'd1,     1'b1, ABORT_AT_START}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_start_req;
  logic        in_echo_level;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        out_trigger_out;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_timed_out;
  logic        out_zone_updated;
  logic [10:0] out_distance_cm;
  logic [1:0]  out_zone;
  logic        out_path_clear;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // register copies
  logic [9:0]  lim_near, lim_mid, lim_far;
  logic [15:0] tmo_ticks;
  logic [7:0]  trig_len;
  logic [1:0]  avg_log2;
  logic        clear_on_tmo;

  // ranger state
  phase_t      ranger_ph;
  logic [15:0] ranger_elapsed;
  logic [15:0] ranger_width;
  logic [18:0] ranger_sum;
  logic [3:0]  ranger_cnt;
  logic [10:0] ranger_dist;
  logic [1:0]  ranger_zone;

  ranger_out_t tick_outputs_q [$];
  ranger_out_t seen, wanted;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned stall_left = 0;
  bit          gaps_on = 1'b1;

  ultrasonic_range_zone_classifier_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_req     (in_start_req),
    .in_echo_level    (in_echo_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_trigger_out  (out_trigger_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_timed_out    (out_timed_out),
    .out_zone_updated (out_zone_updated),
    .out_distance_cm  (out_distance_cm),
    .out_zone         (out_zone),
    .out_path_clear   (out_path_clear),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (fail_count < 40) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [1:0] zone_of(input int unsigned d);
    if (d < lim_near) return ZONE_NEAR;
    if (d < lim_mid) return ZONE_MID;
    if (d < lim_far) return ZONE_FAR;
    return ZONE_NONE;
  endfunction

  task automatic reset_ranger();
    lim_near       = 10'd60;
    lim_mid        = 10'd110;
    lim_far        = 10'd200;
    tmo_ticks      = 16'd25000;
    trig_len       = 8'd10;
    avg_log2       = 2'd0;
    clear_on_tmo   = 1'b1;
    ranger_ph      = PH_IDLE;
    ranger_elapsed = '0;
    ranger_width   = '0;
    ranger_sum     = '0;
    ranger_cnt     = '0;
    ranger_dist    = '0;
    ranger_zone    = ZONE_NONE;
  endtask

  // one microsecond tick of the ranger; returns the pin and status snapshot
  function automatic ranger_out_t step_ranger(input logic start, input logic echo);
    ranger_out_t r;
    int unsigned n;
    int unsigned d;
    r = '0;
    if (ranger_ph == PH_IDLE && start) begin
      ranger_ph      = PH_TRIG;
      ranger_elapsed = '0;
      ranger_width   = '0;
    end
    if (ranger_ph != PH_IDLE) begin
      r.busy = 1'b1;
      case (ranger_ph)
        PH_TRIG: begin
          r.trig = 1'b1;
          if (32'(ranger_elapsed) + 1 >= 32'(trig_len)) ranger_ph = PH_WAIT;
        end
        PH_WAIT: begin
          if (echo) begin
            ranger_ph    = PH_HIGH;
            ranger_width = 16'd1;
          end
        end
        default: begin
          if (echo) begin
            if (ranger_width != 16'hFFFF) ranger_width++;
          end else begin
            n          = 32'd1 << avg_log2;
            r.done     = 1'b1;
            ranger_ph  = PH_IDLE;
            ranger_sum = ranger_sum + 19'(ranger_width);
            ranger_cnt++;
            if (32'(ranger_cnt) >= n) begin
              d = (32'(ranger_sum) * US_CM_NUM) / (US_CM_DEN * n);
              if (d > DIST_CAP) d = DIST_CAP;
              ranger_dist = 11'(d);
              ranger_zone = zone_of(d);
              r.upd       = 1'b1;
              ranger_sum  = '0;
              ranger_cnt  = '0;
            end
          end
        end
      endcase
      if (ranger_elapsed != 16'hFFFF) ranger_elapsed++;
      if (!r.done && ranger_elapsed >= tmo_ticks) begin
        r.done    = 1'b1;
        r.tout    = 1'b1;
        ranger_ph = PH_IDLE;
        if (clear_on_tmo) ranger_zone = ZONE_NONE;
      end
    end
    r.dist_cm = ranger_dist;
    r.zone    = ranger_zone;
    r.clear   = (ranger_zone == ZONE_FAR) || (ranger_zone == ZONE_NONE);
    return r;
  endfunction

  // enter and leave at a falling edge; valid stays high afterwards until the next call
  task automatic put_tick(input logic start, input logic echo, input logic typed = 1'b0,
                          input ranger_out_t want = '0);
    int unsigned gap;
    ranger_out_t r;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_start_req  <= start;
    in_echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    r = step_ranger(start, echo);
    tick_outputs_q.push_back(typed ? want : r);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (tick_outputs_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NEAR_LIMIT: lim_near     = val[9:0];
      CFG_MID_LIMIT:  lim_mid      = val[9:0];
      CFG_FAR_LIMIT:  lim_far      = val[9:0];
      CFG_TIMEOUT:    tmo_ticks    = val;
      CFG_TRIGGER:    trig_len     = val[7:0];
      CFG_AVG_LOG2:   avg_log2     = val[1:0];
      CFG_CLEAR_TMO:  clear_on_tmo = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // end any open measurement: run out the trigger, raise the echo, drop it
  task automatic finish_measurement();
    while (ranger_ph != PH_IDLE) put_tick(1'b0, ranger_ph == PH_WAIT);
  endtask

  task automatic measure_once();
    int unsigned len;
    int unsigned r;
    put_tick(1'b1, 1'($urandom));
    while (ranger_ph == PH_TRIG) put_tick(1'($urandom), 1'($urandom));
    len = $urandom_range(0, 4);
    while (ranger_ph == PH_WAIT && len != 0) begin
      put_tick(1'($urandom), 1'b0);
      len--;
    end
    r = $urandom_range(0, 9);
    if (r < 5) len = $urandom_range(1, 30);
    else if (r < 9) len = $urandom_range(31, 250);
    else len = $urandom_range(251, 1200);
    while (ranger_ph != PH_IDLE && len != 0) begin
      put_tick(1'($urandom), 1'b1);
      len--;
    end
    if (ranger_ph != PH_IDLE) put_tick(1'($urandom), 1'b0);
  endtask

  function automatic logic [15:0] pick_limit();
    int unsigned r;
    logic [9:0]  v;
    r = $urandom_range(0, 9);
    if (r == 0) v = 10'd0;
    else if (r == 1) v = 10'd1023;
    else if (r < 8) v = 10'($urandom_range(0, 24));
    else v = 10'($urandom);
    return {6'($urandom), v};
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= idle_len();
    end
  end

  // compare every result transaction with the oldest pending snapshot
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen = {out_trigger_out, out_busy_res, out_done_res, out_timed_out, out_zone_updated,
              out_distance_cm, out_zone, out_path_clear};
      if (tick_outputs_q.size() == 0) begin
        flag_mismatch("result with nothing pending", 16'(seen), 16'd0);
      end else begin
        wanted = tick_outputs_q.pop_front();
        if (seen.trig !== wanted.trig) flag_mismatch("trigger_out", seen.trig, wanted.trig);
        if (seen.busy !== wanted.busy) flag_mismatch("busy_res", seen.busy, wanted.busy);
        if (seen.done !== wanted.done) flag_mismatch("done_res", seen.done, wanted.done);
        if (seen.tout !== wanted.tout) flag_mismatch("timed_out", seen.tout, wanted.tout);
        if (seen.upd !== wanted.upd) flag_mismatch("zone_updated", seen.upd, wanted.upd);
        if (seen.dist_cm !== wanted.dist_cm) begin
          flag_mismatch("distance_cm", seen.dist_cm, wanted.dist_cm);
        end
        if (seen.zone !== wanted.zone) flag_mismatch("zone", seen.zone, wanted.zone);
        if (seen.clear !== wanted.clear) flag_mismatch("path_clear", seen.clear, wanted.clear);
      end
    end
  end

  initial begin
    int row;
    int unsigned rand_end;
    int unsigned phase_end;
    int unsigned r;
    int unsigned settle;
    logic [15:0] v;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_start_req  = 1'b0;
    in_echo_level = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_NEAR_LIMIT;
    cfg_data      = '0;
    reset_ranger();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < $size(SCRIPT); row++) begin
      if (SCRIPT[row].kind == ROW_WRITE) begin
        drain_results();
        write_reg(SCRIPT[row].reg_idx, SCRIPT[row].reg_val);
      end else begin
        repeat (SCRIPT[row].reps) begin
          put_tick(SCRIPT[row].start, SCRIPT[row].echo, SCRIPT[row].typed, SCRIPT[row].want);
        end
      end
    end

    rand_end = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < rand_end) begin
      // close the measurement and let the output side go quiet before reprogramming
      finish_measurement();
      drain_results();
      gaps_on = ($urandom_range(0, 3) != 0);
      write_reg(CFG_NEAR_LIMIT, pick_limit());
      write_reg(CFG_MID_LIMIT, pick_limit());
      write_reg(CFG_FAR_LIMIT, pick_limit());
      r = $urandom_range(0, 99);
      if (r < 5) v = 16'd0;
      else if (r < 10) v = 16'hFFFF;
      else if (r < 15) v = 16'd1;
      else if (r < 35) v = 16'($urandom_range(2, 60));
      else v = 16'($urandom_range(200, 1500));
      write_reg(CFG_TIMEOUT, v);
      r = $urandom_range(0, 19);
      if (r == 0) v = {8'($urandom), 8'd255};
      else if (r == 1) v = {8'($urandom), 8'd0};
      else v = {8'($urandom), 8'($urandom_range(1, 6))};
      write_reg(CFG_TRIGGER, v);
      write_reg(CFG_AVG_LOG2, 16'($urandom));
      write_reg(CFG_CLEAR_TMO, 16'($urandom));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 16'($urandom));
      phase_end = ticks_sent + $urandom_range(40, 220);
      while (ticks_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 8)) put_tick(1'($urandom), 1'($urandom));
        end else begin
          measure_once();
        end
      end
    end

    finish_measurement();
    in_valid <= 1'b0;
    settle = 0;
    while (tick_outputs_q.size() != 0 && settle < 3000) begin
      @(negedge clk);
      settle++;
    end
    if (tick_outputs_q.size() != 0) begin
      flag_mismatch("results never delivered", 16'(tick_outputs_q.size()), 16'd0);
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> ultrasonic_range_zone_classifier_unit.f
src/urzc_pkg.sv
src/ultrasonic_range_zone_classifier_unit.sv
src/urzc_checker.sv
test/tb_ultrasonic_range_zone_classifier_unit.sv
